/* src/multichannel_biquad_filter_core_macros.svh */
// assertion macros for the filter core rtl
// no dependencies; included by the filter core top, which carries concurrent checks
`ifndef MULTICHANNEL_BIQUAD_FILTER_CORE_MACROS_SVH
`define MULTICHANNEL_BIQUAD_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MBQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mbq_pkg.sv */
// shared types and constants for the multichannel biquad filter core
// no dependencies; imported by every module of the block
`default_nettype none

package mbq_pkg;

   // coefficient format, signed q3.16
   localparam int COEF_BITS = 19;
   localparam int COEF_FRAC = 16;

   // round half up before dropping the coefficient fraction bits
   localparam int ROUND_HALF = 1 << (COEF_FRAC - 1);

   // channel field width of the request
   localparam int CHAN_BITS = 3;

   // register interface
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_COEF    = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK_ONE = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK_TWO = 2'd2;

   // coefficient set handed from the register block to the datapath
   typedef struct packed {
      logic signed [COEF_BITS-1:0] gain;
      logic signed [COEF_BITS-1:0] fb_one;
      logic signed [COEF_BITS-1:0] fb_two;
   } coef_type;

endpackage

`default_nettype wire

/* src/multichannel_biquad_filter_core.sv */
// Multichannel direct-form-I biquad: takes one request per cycle while the
// rsp side does not stall. Each request lands in the input register when
// it is accepted and moves on into the result register, which drives the
// rsp side; while rsp stalls, it waits in the input register.
// The rate is set by the single
// arithmetic stage between those registers: three coefficient multiplies in
// parallel, a three-way sum, rounding and saturation. The per-channel history
// sits in flip-flops that reset clears at once, so there is no clearing pass;
// a request on a channel updates its history as its result is registered,
// so requests on the same channel may follow each other in back-to-back cycles.
// depends on mbq_pkg, mbq_csr, mbq_datapath and the assertion macro header
`default_nettype none

`include "multichannel_biquad_filter_core_macros.svh"

module multichannel_biquad_filter_core import mbq_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 16,
   parameter int DATA_BITS   = ((SAMPLE_BITS + CHAN_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_BITS-1:0]     req_tdata,   // sample_in, channel, zero pad
   input  logic                     req_tlast,   // block_end
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [DATA_BITS-1:0]     rsp_tdata,   // sample_out, channel_out, zero pad
   output logic                     rsp_tlast,   // block_end_out
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   coef_type                      coef;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CHAN_BITS-1:0]          s1_chan_ff;
   logic                          s1_last_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [CHAN_BITS-1:0]          rsp_chan_ff;
   logic                          rsp_last_ff;

   logic                          req_take;
   logic                          s1_move;
   logic signed [SAMPLE_BITS-1:0] filt_out;

   // coefficient registers
   mbq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // handshake: input stage moves when the result register is free or being taken
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         s1_chan_ff   <= req_tdata[SAMPLE_BITS+CHAN_BITS-1:SAMPLE_BITS];
         s1_last_ff   <= req_tlast;
      end
   end

   // history and arithmetic
   mbq_datapath #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .coef    (coef),
      .sample  (s1_sample_ff),
      .channel (s1_chan_ff),
      .update  (s1_move),
      .result  (filt_out)
   );

   // result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_sample_ff <= filt_out;
         rsp_chan_ff   <= s1_chan_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'({rsp_chan_ff, rsp_sample_ff});
   assign rsp_tlast  = rsp_last_ff;

   // a request is only taken when the input register is free or draining
   `MBQ_ASSERT_NOW(a_take_free, clock, reset, req_take, !s1_valid_ff || s1_move, "request taken over a held stage")
   // a sample leaving the input register shows up as a result
   `MBQ_ASSERT_NEXT(a_move_rsp, clock, reset, s1_move, rsp_valid_ff, "moved sample lost")
   // a held input stage keeps its sample
   `MBQ_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_move, s1_valid_ff && $stable(s1_sample_ff) && $stable(s1_chan_ff), "held sample changed")

endmodule

`default_nettype wire

/* src/mbq_csr.sv */
// coefficient registers behind a simple apb-style port
// depends on mbq_pkg
`default_nettype none

module mbq_csr import mbq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output coef_type                 coef
);

   coef_type                coef_ff;
   coef_type                coef_in;
   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic [COEF_BITS-1:0]    wr_coef;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_coef    = csr_pwdata[COEF_BITS-1:0];
   assign coef       = coef_ff;

   // register write decode, unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN_COEF:    coef_in.gain   = wr_coef;
            REG_FEEDBACK_ONE: coef_in.fb_one = wr_coef;
            REG_FEEDBACK_TWO: coef_in.fb_two = wr_coef;
            default:          coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // read back, sign extended to the bus width
   always_comb begin
      unique case (reg_idx)
         REG_GAIN_COEF:    csr_prdata = CSR_DATA_BITS'(coef_ff.gain);
         REG_FEEDBACK_ONE: csr_prdata = CSR_DATA_BITS'(coef_ff.fb_one);
         REG_FEEDBACK_TWO: csr_prdata = CSR_DATA_BITS'(coef_ff.fb_two);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* src/mbq_datapath.sv */
// per-channel history and the biquad arithmetic for one sample
// depends on mbq_pkg
`default_nettype none

module mbq_datapath import mbq_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  coef_type                      coef,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [CHAN_BITS-1:0]          channel,
   input  logic                          update,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TAP_BITS  = SAMPLE_BITS + 2;
   localparam int FF_BITS   = TAP_BITS + COEF_BITS;
   localparam int FB_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = FF_BITS + 2;
   localparam int RND_BITS  = ACC_BITS - COEF_FRAC;
   localparam logic signed [RND_BITS-1:0] SAT_HI =
      RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_BITS-1:0] SAT_LO = -SAT_HI - RND_BITS'(1);

   logic signed [SAMPLE_BITS-1:0] x1_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x2_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y1_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y2_ff [CHANNELS];

   logic                          chan_ok;
   logic [IDX_BITS-1:0]           idx;
   logic signed [SAMPLE_BITS-1:0] x1;
   logic signed [SAMPLE_BITS-1:0] x2;
   logic signed [SAMPLE_BITS-1:0] y1;
   logic signed [SAMPLE_BITS-1:0] y2;
   logic signed [TAP_BITS-1:0]    x1_dbl;
   logic signed [TAP_BITS-1:0]    tap_sum;
   logic signed [FF_BITS-1:0]     ff_prod;
   logic signed [FB_BITS-1:0]     fb1_prod;
   logic signed [FB_BITS-1:0]     fb2_prod;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [ACC_BITS-1:0]    acc_rnd;
   logic signed [RND_BITS-1:0]    rounded;

   // out-of-range channels see zero history and leave it untouched
   assign chan_ok = (32'(channel) < CHANNELS);
   assign idx     = IDX_BITS'(channel);

   assign x1 = chan_ok ? x1_ff[idx] : '0;
   assign x2 = chan_ok ? x2_ff[idx] : '0;
   assign y1 = chan_ok ? y1_ff[idx] : '0;
   assign y2 = chan_ok ? y2_ff[idx] : '0;

   // feed-forward taps share the gain coefficient, so sum x + 2*x1 + x2 first
   assign x1_dbl  = TAP_BITS'(x1) <<< 1;
   assign tap_sum = TAP_BITS'(sample) + x1_dbl + TAP_BITS'(x2);

   assign ff_prod  = FF_BITS'(coef.gain) * FF_BITS'(tap_sum);
   assign fb1_prod = FB_BITS'(coef.fb_one) * FB_BITS'(y1);
   assign fb2_prod = FB_BITS'(coef.fb_two) * FB_BITS'(y2);

   assign acc = ACC_BITS'(ff_prod) - ACC_BITS'(fb1_prod) - ACC_BITS'(fb2_prod);

   // round half up, drop fraction bits, clamp to the sample range
   assign acc_rnd = acc + ACC_BITS'(ROUND_HALF);
   assign rounded = acc_rnd[ACC_BITS-1:COEF_FRAC];

   always_comb begin
      priority if (rounded > SAT_HI) begin
         result = SAT_HI[SAMPLE_BITS-1:0];
      end else if (rounded < SAT_LO) begin
         result = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         result = rounded[SAMPLE_BITS-1:0];
      end
   end

   // history shift for the channel of the sample that moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (update && chan_ok) begin
         x1_ff[idx] <= sample;
         x2_ff[idx] <= x1;
         y1_ff[idx] <= result;
         y2_ff[idx] <= y1;
      end
   end

endmodule

`default_nettype wire

/* test/multichannel_biquad_filter_checker.sv */
// checker for the multichannel biquad filter core: follows register writes,
// predicts every filtered sample and compares the rsp stream field by field
// depends on mbq_pkg
module multichannel_biquad_filter_checker import mbq_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 16,
   parameter int DATA_BITS   = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [DATA_BITS-1:0]     req_tdata,    // sample_in, channel, zero pad
   input  logic                     req_tlast,    // block_end
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [DATA_BITS-1:0]     rsp_tdata,    // sample_out, channel_out, zero pad
   input  logic                     rsp_tlast,    // block_end_out
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending_count
);

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_BITS-1:0]          chan;
      logic                          last;
   } filtered_sample_type;

   // coefficient copy and per-channel history
   logic signed [COEF_BITS-1:0]   gain_coef, feedback_one, feedback_two;
   logic signed [SAMPLE_BITS-1:0] prev_in [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] older_in [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] prev_out [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] older_out [CHANNELS];

   filtered_sample_type filtered_queue[$];
   filtered_sample_type oldest;
   logic [REG_IDX_BITS-1:0] reg_index;

   assign reg_index = csr_paddr[CSR_ADDR_BITS-1:2];

   // filter one sample with its channel history, then shift the history
   function automatic filtered_sample_type filter_sample(
         input logic signed [SAMPLE_BITS-1:0] x,
         input logic [CHAN_BITS-1:0] ch,
         input logic last);
      longint x1, x2, y1, y2, acc, rounded;
      bit in_range;
      filtered_sample_type r;
      in_range = (ch < CHANNELS);
      x1 = 0; x2 = 0; y1 = 0; y2 = 0;
      if (in_range) begin
         x1 = longint'(prev_in[ch]);
         x2 = longint'(older_in[ch]);
         y1 = longint'(prev_out[ch]);
         y2 = longint'(older_out[ch]);
      end
      acc = longint'(gain_coef) * longint'(x) + 2 * longint'(gain_coef) * x1
          + longint'(gain_coef) * x2 - longint'(feedback_one) * y1
          - longint'(feedback_two) * y2;
      // round half up, then clamp to the sample range
      rounded = (acc + longint'(ROUND_HALF)) >>> COEF_FRAC;
      if (rounded > SAMPLE_MAX) rounded = SAMPLE_MAX;
      if (rounded < SAMPLE_MIN) rounded = SAMPLE_MIN;
      r.sample = rounded[SAMPLE_BITS-1:0];
      r.chan   = ch;
      r.last   = last;
      if (in_range) begin
         older_in[ch]  = prev_in[ch];
         prev_in[ch]   = x;
         older_out[ch] = prev_out[ch];
         prev_out[ch]  = r.sample;
      end
      return r;
   endfunction

   task automatic flag_failure(input string what, input longint want, input longint got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_coef    = '0;
         feedback_one = '0;
         feedback_two = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            prev_in[c]   = '0;
            older_in[c]  = '0;
            prev_out[c]  = '0;
            older_out[c] = '0;
         end
         filtered_queue.delete();
      end else begin
         // coefficient writes; unmapped indexes change nothing
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index)
               REG_GAIN_COEF:    gain_coef    = csr_pwdata[COEF_BITS-1:0];
               REG_FEEDBACK_ONE: feedback_one = csr_pwdata[COEF_BITS-1:0];
               REG_FEEDBACK_TWO: feedback_two = csr_pwdata[COEF_BITS-1:0];
               default: ;
            endcase
         end
         // readback of the coefficient bits
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            case (reg_index)
               REG_GAIN_COEF:
                  if (csr_prdata[COEF_BITS-1:0] !== gain_coef)
                     flag_failure("gain_coef readback", longint'(gain_coef),
                                  longint'($signed(csr_prdata[COEF_BITS-1:0])));
               REG_FEEDBACK_ONE:
                  if (csr_prdata[COEF_BITS-1:0] !== feedback_one)
                     flag_failure("feedback_one readback", longint'(feedback_one),
                                  longint'($signed(csr_prdata[COEF_BITS-1:0])));
               REG_FEEDBACK_TWO:
                  if (csr_prdata[COEF_BITS-1:0] !== feedback_two)
                     flag_failure("feedback_two readback", longint'(feedback_two),
                                  longint'($signed(csr_prdata[COEF_BITS-1:0])));
               default: ;
            endcase
         end
         // compare a filtered sample with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result with no request waiting: tdata %h, tlast %b",
                           rsp_tdata, rsp_tlast);
            end else begin
               oldest = filtered_queue.pop_front();
               if (rsp_tdata[SAMPLE_BITS-1:0] !== oldest.sample)
                  flag_failure("sample_out", longint'(oldest.sample),
                               longint'($signed(rsp_tdata[SAMPLE_BITS-1:0])));
               if (rsp_tdata[SAMPLE_BITS +: CHAN_BITS] !== oldest.chan)
                  flag_failure("channel_out", longint'(oldest.chan),
                               longint'(rsp_tdata[SAMPLE_BITS +: CHAN_BITS]));
               if (rsp_tlast !== oldest.last)
                  flag_failure("block_end_out", longint'(oldest.last), longint'(rsp_tlast));
               if ((rsp_tdata >> (SAMPLE_BITS + CHAN_BITS)) !== '0)
                  flag_failure("tdata pad", 0,
                               longint'(rsp_tdata >> (SAMPLE_BITS + CHAN_BITS)));
            end
         end
         // predict the result of an accepted request
         if (req_tvalid && req_tready)
            filtered_queue.push_back(filter_sample(req_tdata[SAMPLE_BITS-1:0],
                                                   req_tdata[SAMPLE_BITS +: CHAN_BITS],
                                                   req_tlast));
      end
      pending_count = filtered_queue.size();
   end

endmodule

/* test/tb_multichannel_biquad_filter_core.sv */
// testbench top for the multichannel biquad filter core: drives requests and
// coefficient writes, stalls the result side, and reports the verdict
// depends on mbq_pkg, the filter core and multichannel_biquad_filter_checker
module tb_multichannel_biquad_filter_core;
   import mbq_pkg::*;

   localparam int CHANNELS        = 8;
   localparam int SAMPLE_BITS     = 16;
   localparam int DATA_BITS       = ((SAMPLE_BITS + CHAN_BITS + 7) / 8) * 8;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 153;
   localparam int COEF_ONE        = 1 << COEF_FRAC;
   localparam int COEF_MAX        = (1 << (COEF_BITS - 1)) - 1;
   localparam int COEF_MIN        = -(1 << (COEF_BITS - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
      SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
      SAMPLE_BITS'(-(1 << (SAMPLE_BITS - 1)));

   localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

   typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_STALLS} ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_BITS-1:0]     req_tdata = '0;   // sample_in, channel, zero pad
   logic                     req_tlast = 1'b0; // block_end
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]     rsp_tdata;        // sample_out, channel_out, zero pad
   logic                     rsp_tlast;        // block_end_out
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       fail_count;
   int                       pending_count;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_left = 0;
   int             ready_hold = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multichannel_biquad_filter_core #(
      .CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS), .DATA_BITS(DATA_BITS)
   ) dut (.*);

   multichannel_biquad_filter_checker #(
      .CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS), .DATA_BITS(DATA_BITS)
   ) filter_check (.*);

   // result side backpressure, switching between patterns
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(20, 300);
      end else begin
         ready_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready = 1'b1;
         READY_MOSTLY: rsp_tready = ($urandom_range(0, 3) != 0);
         READY_RARELY: rsp_tready = ($urandom_range(0, 3) == 0);
         default: begin
            if (ready_hold > 0) begin
               ready_hold--;
               rsp_tready = 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               ready_hold = $urandom_range(4, 24);
               rsp_tready = 1'b0;
            end else begin
               rsp_tready = 1'b1;
            end
         end
      endcase
   end

   task automatic send_request(input logic signed [SAMPLE_BITS-1:0] sample,
                               input logic [CHAN_BITS-1:0] chan, input logic last);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {{(DATA_BITS - SAMPLE_BITS - CHAN_BITS){1'b0}}, chan, sample};
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
   endtask

   // idle the request side, with noise on the data lines
   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = DATA_BITS'($urandom);
         req_tlast  = 1'($urandom_range(0, 1));
      end
   endtask

   // hold off until every predicted result has come back
   task automatic wait_for_results;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input logic [REG_IDX_BITS-1:0] idx, input logic write,
                             input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_pwdata  = $urandom;
   endtask

   // coefficient in the low bits, noise above it
   function automatic logic [CSR_DATA_BITS-1:0] coef_word(input int value);
      logic [CSR_DATA_BITS-1:0] mask;
      mask = (1 << COEF_BITS) - 1;
      return ($urandom & ~mask) | (value & mask);
   endfunction

   // write all coefficients plus an unmapped index, then read them back
   task automatic load_coefs(input int gain, input int fb_one, input int fb_two);
      csr_access(REG_GAIN_COEF, 1'b1, coef_word(gain));
      csr_access(REG_FEEDBACK_ONE, 1'b1, coef_word(fb_one));
      csr_access(REG_FEEDBACK_TWO, 1'b1, coef_word(fb_two));
      csr_access(REG_UNMAPPED, 1'b1, $urandom);
      csr_access(REG_GAIN_COEF, 1'b0, '0);
      csr_access(REG_FEEDBACK_ONE, 1'b0, '0);
      csr_access(REG_FEEDBACK_TWO, 1'b0, '0);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample;
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3, 4: return SAMPLE_BITS'($urandom);
         default: return SAMPLE_BITS'(int'($urandom_range(0, 2048)) - 1024);
      endcase
   endfunction

   // random requests in bursts, channels often repeated to build history
   task automatic feed_samples(input int count);
      int sent;
      int burst;
      logic [CHAN_BITS-1:0] chan;
      sent = 0;
      chan = '0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if ($urandom_range(0, 1))
               chan = CHAN_BITS'($urandom_range(0, (1 << CHAN_BITS) - 1));
            send_request(pick_sample(), chan, $urandom_range(0, 7) == 0);
            sent++;
         end
         case ($urandom_range(0, 9))
            4, 5, 6, 7: pause_sender($urandom_range(1, 4));
            8:          pause_sender($urandom_range(5, 30));
            9:          wait_for_results();
            default: ;
         endcase
      end
   endtask

   initial begin
      int gain, fb_one, fb_two, limit;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // unit gain, no feedback: impulse gives the 1, 2, 1 taps; saturation both ways
      load_coefs(COEF_ONE, 0, 0);
      send_request(1000, 0, 1'b0);
      send_request(0, 0, 1'b0);
      send_request(0, 0, 1'b0);
      send_request(0, 0, 1'b1);
      send_request(SAMPLE_MAX, 1, 1'b0);
      send_request(SAMPLE_MAX, 1, 1'b1);
      send_request(SAMPLE_MIN, 2, 1'b0);
      send_request(SAMPLE_MIN, 2, 1'b1);
      wait_for_results();

      // half gain: exact halves round up
      load_coefs(COEF_ONE / 2, 0, 0);
      send_request(1, 3, 1'b0);
      send_request(-1, 4, 1'b0);
      send_request(-1, 4, 1'b1);
      wait_for_results();

      // coefficient extremes
      load_coefs(COEF_MAX, COEF_MIN, COEF_MAX);
      send_request(SAMPLE_MAX, 5, 1'b0);
      send_request(SAMPLE_MIN, 5, 1'b1);
      send_request(1, 6, 1'b0);
      send_request(-1, 6, 1'b0);
      send_request(0, 7, 1'b1);
      wait_for_results();
      load_coefs(COEF_MIN, COEF_MAX, COEF_MIN);
      send_request(SAMPLE_MIN, 7, 1'b0);
      send_request(SAMPLE_MAX, 7, 1'b0);
      send_request(SAMPLE_MAX, 0, 1'b1);
      send_request(-1, 1, 1'b0);

      // random phases, each with its own coefficient set
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         case (phase % 4)
            0: begin
               gain   = int'($urandom_range(0, COEF_MAX - COEF_MIN)) + COEF_MIN;
               fb_one = int'($urandom_range(0, COEF_MAX - COEF_MIN)) + COEF_MIN;
               fb_two = int'($urandom_range(0, COEF_MAX - COEF_MIN)) + COEF_MIN;
            end
            1: begin
               // stable pole pair so the output stays in range
               fb_two = int'($urandom_range(0, 117964)) - 58982;
               limit  = ((COEF_ONE + fb_two) * 9) / 10;
               fb_one = int'($urandom_range(0, 2 * limit)) - limit;
               gain   = int'($urandom_range(0, 16384)) - 8192;
            end
            2: begin
               gain   = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
               fb_one = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
               fb_two = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            end
            default: begin
               gain   = int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
               fb_one = int'($urandom_range(0, 8192)) - 4096;
               fb_two = 0;
            end
         endcase
         load_coefs(gain, fb_one, fb_two);
         feed_samples(ITEMS_PER_PHASE);
      end

      wait_for_results();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/mbq_pkg.sv
src/mbq_csr.sv
src/mbq_datapath.sv
src/multichannel_biquad_filter_core.sv
test/multichannel_biquad_filter_checker.sv
test/tb_multichannel_biquad_filter_core.sv
